// ===== rtl/sprite_row_span_setup_assert.svh =====
// Assertion macros shared by the sprite row span setup modules.
`ifndef SPRITE_ROW_SPAN_SETUP_ASSERT_SVH
`define SPRITE_ROW_SPAN_SETUP_ASSERT_SVH

// Same-cycle implication, checked on the rising edge of clock outside reset.
`define SRSS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SRSS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/srss_pkg.sv =====
// Shared types and constants for the sprite row span setup block.
package srss_pkg;

   localparam logic [1:0] CSR_FLIP_X      = 2'd0;
   localparam logic [1:0] CSR_FLIP_Y      = 2'd1;
   localparam logic [1:0] CSR_SINGLE_BANK = 2'd2;

   localparam logic [15:0] CODE_EMPTY      = 16'hFFFF;
   localparam logic [15:0] FLIP_WRAP_LIMIT = 16'd65000;

   localparam logic [21:0] ROM_BANK1_BASE    = 22'h040000;
   localparam logic [21:0] ROM_BANK2_BASE    = 22'h080000;
   localparam logic [21:0] ROM_BANK2_HI_BASE = 22'h0C0000;

   localparam logic signed [17:0] WRAP_SPAN  = 18'sd65536;
   localparam logic signed [17:0] SCREEN_W   = 18'sd320;
   localparam logic signed [17:0] SCREEN_H   = 18'sd256;
   localparam logic signed [17:0] LINE_FIRST = 18'sd16;
   localparam logic signed [17:0] LINE_LAST  = 18'sd239;

   localparam logic [8:0] PAL_OFFSET = 9'h010;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DECODE = 4'b0010,
      ST_PREP   = 4'b0100,
      ST_ROWS   = 4'b1000
   } state_type;

   typedef struct packed {
      logic load;
      logic decode;
      logic prep;
      logic row;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic row_end;
   } stat_type;

   // size code 2 and 3 both give 64
   function automatic logic [6:0] size_of(input logic [1:0] sel);
      logic [6:0] s;
      unique case (sel)
         2'd0:    s = 7'd16;
         2'd1:    s = 7'd32;
         default: s = 7'd64;
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/srss_ctrl.sv =====
// Sequencer for the sprite row span setup: decode, prepare, then one row a cycle.
`include "sprite_row_span_setup_assert.svh"

module srss_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output srss_pkg::cmd_type cmd,
   input  srss_pkg::stat_type stat
);

   srss_pkg::state_type state_ff, state_in;
   logic                accept;

   assign accept = start && (state_ff == srss_pkg::ST_IDLE);
   assign busy   = (state_ff != srss_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srss_pkg::ST_IDLE: begin
            if (start) state_in = srss_pkg::ST_DECODE;
         end
         srss_pkg::ST_DECODE: begin
            state_in = stat.skip ? srss_pkg::ST_IDLE : srss_pkg::ST_PREP;
         end
         srss_pkg::ST_PREP: begin
            state_in = srss_pkg::ST_ROWS;
         end
         srss_pkg::ST_ROWS: begin
            if (stat.row_end) state_in = srss_pkg::ST_IDLE;
         end
         default: state_in = srss_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.load   = accept;
      cmd.decode = (state_ff == srss_pkg::ST_DECODE);
      cmd.prep   = (state_ff == srss_pkg::ST_PREP);
      cmd.row    = (state_ff == srss_pkg::ST_ROWS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srss_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `SRSS_ASSERT_NEXT(a_accept_decodes, accept, state_ff == srss_pkg::ST_DECODE, "accept did not start decode")
   `SRSS_ASSERT_NEXT(a_row_end_idles, cmd.row && stat.row_end, !busy, "block still busy after last row")
   `SRSS_ASSERT_NEXT(a_prep_rows, cmd.prep, cmd.row, "prepare not followed by rows")

endmodule

// ===== rtl/srss_dp.sv =====
// Datapath: entry decode, bank and flip math, per-row span registers.
`include "sprite_row_span_setup_assert.svh"

module srss_dp (
   input  logic               clock,
   input  logic               reset,
   input  srss_pkg::cmd_type  cmd,
   output srss_pkg::stat_type stat,
   input  logic               cfg_we,
   input  logic [1:0]         cfg_index,
   input  logic               cfg_data,
   input  logic [15:0]        tile_code,
   input  logic [15:0]        x_word,
   input  logic [15:0]        y_word,
   input  logic [15:0]        attr_word,
   output logic               rsp_strobe,
   output logic [7:0]         rsp_screen_line,
   output logic               rsp_from_sprite_ram,
   output logic [21:0]        rsp_row_address,
   output logic signed [16:0] rsp_x_start,
   output logic [6:0]         rsp_span_width,
   output logic               rsp_mirror_x,
   output logic [8:0]         rsp_palette_base,
   output logic               rsp_front_priority,
   output logic               rsp_shadow_enabled,
   output logic               rsp_last_row
);

   // configuration
   logic flip_x_ff, flip_y_ff, single_bank_ff;

   // captured entry
   logic [15:0] code_ff, x_ff, y_ff, attr_ff;

   // decoded entry
   logic [21:0]        base_ff;
   logic               ram_ff;
   logic [6:0]         width_ff;
   logic [5:0]         hm1_ff;
   logic               mirx_ff, miry_ff;
   logic signed [17:0] yf_ff, xf_ff;

   // row walk
   logic signed [17:0] sy_ff;
   logic signed [16:0] xstart_ff;
   logic [21:0]        addr_ff;
   logic [5:0]         row_ff;

   // response registers
   logic               strobe_ff;
   logic [7:0]         line_ff;
   logic [21:0]        raddr_ff;
   logic               last_ff;

   // decode logic
   logic [6:0]         h, w;
   logic [21:0]        bank_base;
   logic               bank_ram;
   logic [15:0]        code_cut, code_m;
   logic signed [17:0] h_ext, w_ext, y_ext, x_ext, y_wr, x_wr, yf_in, xf_in;

   // prepare logic
   logic signed [17:0] y_off, x_off, hm1_ext;

   // row logic
   logic visible, row_end, edge_line;

   assign h     = srss_pkg::size_of(attr_ff[7:6]);
   assign w     = srss_pkg::size_of(attr_ff[5:4]);
   assign h_ext = signed'({11'd0, h});
   assign w_ext = signed'({11'd0, w});
   assign y_ext = signed'({2'b00, y_ff});
   assign x_ext = signed'({2'b00, x_ff});

   assign stat.skip = (code_ff == srss_pkg::CODE_EMPTY) || !attr_ff[15];

   always_comb begin
      bank_base = '0;
      bank_ram  = 1'b0;
      code_cut  = code_ff;
      if (!single_bank_ff) begin
         unique case (code_ff[13:12])
            2'd0: bank_base = '0;
            2'd1: bank_base = srss_pkg::ROM_BANK1_BASE;
            2'd2: bank_base = code_ff[14] ? srss_pkg::ROM_BANK2_HI_BASE
                                          : srss_pkg::ROM_BANK2_BASE;
            default: bank_ram = 1'b1;
         endcase
         code_cut = {4'd0, code_ff[11:0]};
      end
   end

   always_comb begin
      code_m = code_cut;
      priority if ((h & w) == 7'd64) code_m = code_cut & ~16'h0008;
      else if ((h & w) == 7'd32)     code_m = code_cut & ~16'h0003;
      else if ((h | w) == 7'd48)     code_m = code_cut & ~16'h0001;
      else                           code_m = code_cut;
   end

   // screen flip, with positions past the hack limit taken as negative
   always_comb begin
      y_wr  = (y_ff > srss_pkg::FLIP_WRAP_LIMIT) ? y_ext - srss_pkg::WRAP_SPAN : y_ext;
      x_wr  = (x_ff > srss_pkg::FLIP_WRAP_LIMIT) ? x_ext - srss_pkg::WRAP_SPAN : x_ext;
      yf_in = flip_y_ff ? srss_pkg::SCREEN_H - y_wr - h_ext : y_ext;
      xf_in = flip_x_ff ? srss_pkg::SCREEN_W - x_wr - w_ext : x_ext;
   end

   // off-screen wrap and first screen line
   assign hm1_ext = signed'({12'd0, hm1_ff});
   assign y_off   = (yf_ff >= srss_pkg::SCREEN_H) ? yf_ff - srss_pkg::WRAP_SPAN : yf_ff;
   assign x_off   = (xf_ff >= srss_pkg::SCREEN_W) ? xf_ff - srss_pkg::WRAP_SPAN : xf_ff;

   // visible rows are contiguous, so the last one sits on the edge line the walk heads to
   assign visible   = (sy_ff >= srss_pkg::LINE_FIRST) && (sy_ff <= srss_pkg::LINE_LAST);
   assign edge_line = miry_ff ? (sy_ff == srss_pkg::LINE_FIRST) : (sy_ff == srss_pkg::LINE_LAST);
   assign row_end   = (row_ff == hm1_ff);
   assign stat.row_end = row_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         flip_x_ff      <= 1'b0;
         flip_y_ff      <= 1'b0;
         single_bank_ff <= 1'b0;
         strobe_ff      <= 1'b0;
      end else begin
         if (cfg_we) begin
            unique case (cfg_index)
               srss_pkg::CSR_FLIP_X:      flip_x_ff      <= cfg_data;
               srss_pkg::CSR_FLIP_Y:      flip_y_ff      <= cfg_data;
               srss_pkg::CSR_SINGLE_BANK: single_bank_ff <= cfg_data;
               default: ;
            endcase
         end
         strobe_ff <= cmd.row && visible;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         code_ff <= tile_code;
         x_ff    <= x_word;
         y_ff    <= y_word;
         attr_ff <= attr_word;
      end
      if (cmd.decode) begin
         base_ff  <= bank_base + {code_m, 6'd0};
         ram_ff   <= bank_ram;
         width_ff <= w;
         hm1_ff   <= 6'(h - 7'd1);
         mirx_ff  <= attr_ff[8] ^ flip_x_ff;
         miry_ff  <= attr_ff[9] ^ flip_y_ff;
         yf_ff    <= yf_in;
         xf_ff    <= xf_in;
      end
      if (cmd.prep) begin
         sy_ff     <= miry_ff ? y_off + hm1_ext : y_off;
         xstart_ff <= x_off[16:0];
         addr_ff   <= base_ff;
         row_ff    <= '0;
      end
      if (cmd.row) begin
         line_ff  <= sy_ff[7:0];
         raddr_ff <= addr_ff;
         last_ff  <= row_end || edge_line;
         sy_ff    <= miry_ff ? sy_ff - 18'sd1 : sy_ff + 18'sd1;
         addr_ff  <= addr_ff + {17'd0, width_ff[6:2]};
         row_ff   <= row_ff + 6'd1;
      end
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_screen_line     = line_ff;
   assign rsp_from_sprite_ram = ram_ff;
   assign rsp_row_address     = raddr_ff;
   assign rsp_x_start         = xstart_ff;
   assign rsp_span_width      = width_ff;
   assign rsp_mirror_x        = mirx_ff;
   assign rsp_palette_base    = ({5'd0, attr_ff[3:0]} + srss_pkg::PAL_OFFSET) << 4;
   assign rsp_front_priority  = attr_ff[14];
   assign rsp_shadow_enabled  = !attr_ff[10];
   assign rsp_last_row        = last_ff;

   `SRSS_ASSERT_NOW(a_line_visible, strobe_ff, (line_ff >= 8'd16) && (line_ff <= 8'd239), "span on a hidden line")
   `SRSS_ASSERT_NEXT(a_last_closes, strobe_ff && last_ff, !strobe_ff, "span after the last row")
   `SRSS_ASSERT_NEXT(a_row_steps_addr, cmd.row && !row_end, row_ff != 6'd0, "row counter did not advance")

endmodule

// ===== rtl/sprite_row_span_setup.sv =====
// Top level of the sprite row span setup block.
// One sprite list entry is taken when start is high and busy is low. An enabled
// entry holds busy after the accept through decode, prepare and one row step per
// sprite row (h = 16, 32 or 64), set by the row walk, which steps one row per
// cycle; a new entry may start in the cycle after the last row. A skipped entry
// holds busy for one cycle. Each visible row gives one beat on the rsp_ ports,
// marked by rsp_strobe for one cycle, in the cycle after its row step; the
// receiver cannot stall and must take every beat. The final beat of an entry
// carries rsp_last_row. Configuration writes are always ready and are meant to be
// made while the block is idle.
module sprite_row_span_setup (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [15:0]        req_tile_code,
   input  logic [15:0]        req_x_word,
   input  logic [15:0]        req_y_word,
   input  logic [15:0]        req_attr_word,
   output logic               rsp_strobe,
   output logic [7:0]         rsp_screen_line,
   output logic               rsp_from_sprite_ram,
   output logic [21:0]        rsp_row_address,
   output logic signed [16:0] rsp_x_start,
   output logic [6:0]         rsp_span_width,
   output logic               rsp_mirror_x,
   output logic [8:0]         rsp_palette_base,
   output logic               rsp_front_priority,
   output logic               rsp_shadow_enabled,
   output logic               rsp_last_row,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic               csr_data
);

   srss_pkg::cmd_type  cmd;
   srss_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   srss_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   srss_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .cfg_we              (csr_valid && csr_ready),
      .cfg_index           (csr_index),
      .cfg_data            (csr_data),
      .tile_code           (req_tile_code),
      .x_word              (req_x_word),
      .y_word              (req_y_word),
      .attr_word           (req_attr_word),
      .rsp_strobe          (rsp_strobe),
      .rsp_screen_line     (rsp_screen_line),
      .rsp_from_sprite_ram (rsp_from_sprite_ram),
      .rsp_row_address     (rsp_row_address),
      .rsp_x_start         (rsp_x_start),
      .rsp_span_width      (rsp_span_width),
      .rsp_mirror_x        (rsp_mirror_x),
      .rsp_palette_base    (rsp_palette_base),
      .rsp_front_priority  (rsp_front_priority),
      .rsp_shadow_enabled  (rsp_shadow_enabled),
      .rsp_last_row        (rsp_last_row)
   );

endmodule

// ===== sim/span_checker.sv =====
// Span checker: predicts the row spans of each accepted sprite entry and compares the beats.
`timescale 1ns / 1ps

module span_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [15:0]        req_tile_code,
   input  logic [15:0]        req_x_word,
   input  logic [15:0]        req_y_word,
   input  logic [15:0]        req_attr_word,
   input  logic               rsp_strobe,
   input  logic [7:0]         rsp_screen_line,
   input  logic               rsp_from_sprite_ram,
   input  logic [21:0]        rsp_row_address,
   input  logic signed [16:0] rsp_x_start,
   input  logic [6:0]         rsp_span_width,
   input  logic               rsp_mirror_x,
   input  logic [8:0]         rsp_palette_base,
   input  logic               rsp_front_priority,
   input  logic               rsp_shadow_enabled,
   input  logic               rsp_last_row,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic               csr_data,
   output int                 spans_due,
   output int                 fail_count
);

   typedef struct {
      logic [7:0]         line;
      logic               ram;
      logic [21:0]        addr;
      logic signed [16:0] x_start;
      logic [6:0]         width;
      logic               mirror;
      logic [8:0]         pal;
      logic               pri;
      logic               shadow;
      logic               last;
   } span_beat_type;

   span_beat_type pending_spans[$];
   logic cfg_flip_x;
   logic cfg_flip_y;
   logic cfg_single_bank;
   int   mismatches = 0;

   task automatic predict_spans(input logic [15:0] code_w, x_w, y_w, attr_w);
      span_beat_type rows[64];
      logic [15:0] code;
      logic [21:0] base;
      logic [31:0] addr_sum;
      logic        ram, fx, fy;
      int          height, width, xpos, ypos, sy, n, r;
      if (code_w == srss_pkg::CODE_EMPTY || !attr_w[15]) return;
      code   = code_w;
      base   = '0;
      ram    = 1'b0;
      height = (attr_w[7:6] >= 2'd2) ? 64 : (16 << attr_w[7:6]);
      width  = (attr_w[5:4] >= 2'd2) ? 64 : (16 << attr_w[5:4]);
      fy     = attr_w[9];
      fx     = attr_w[8];
      if (!cfg_single_bank) begin
         unique case (code[13:12])
            2'd0: base = '0;
            2'd1: base = srss_pkg::ROM_BANK1_BASE;
            2'd2: base = code[14] ? srss_pkg::ROM_BANK2_HI_BASE : srss_pkg::ROM_BANK2_BASE;
            default: ram = 1'b1;
         endcase
         code[15:12] = 4'h0;
      end
      // size-dependent code masking
      if ((height & width) == 64) code[3] = 1'b0;
      else if ((height & width) == 32) code[1:0] = 2'b00;
      else if ((height | width) == 48) code[0] = 1'b0;
      addr_sum = 32'(base) + 32'(code) * 32'h40;

      xpos = int'(x_w);
      ypos = int'(y_w);
      // flipped positions just under the wrap point count as negative
      if (cfg_flip_y) begin
         if (ypos > int'(srss_pkg::FLIP_WRAP_LIMIT)) ypos -= int'(srss_pkg::WRAP_SPAN);
         ypos = int'(srss_pkg::SCREEN_H) - ypos - height;
         fy   = ~fy;
      end
      if (cfg_flip_x) begin
         if (xpos > int'(srss_pkg::FLIP_WRAP_LIMIT)) xpos -= int'(srss_pkg::WRAP_SPAN);
         xpos = int'(srss_pkg::SCREEN_W) - xpos - width;
         fx   = ~fx;
      end
      if (xpos >= int'(srss_pkg::SCREEN_W)) xpos -= int'(srss_pkg::WRAP_SPAN);
      if (ypos >= int'(srss_pkg::SCREEN_H)) ypos -= int'(srss_pkg::WRAP_SPAN);

      n = 0;
      for (r = 0; r < height; r++) begin
         sy = fy ? (ypos + height - 1 - r) : (ypos + r);
         if (sy >= int'(srss_pkg::LINE_FIRST) && sy <= int'(srss_pkg::LINE_LAST)) begin
            rows[n].line    = sy[7:0];
            rows[n].ram     = ram;
            rows[n].addr    = 22'(addr_sum + 32'(r * (width / 4)));
            rows[n].x_start = 17'(xpos);
            rows[n].width   = 7'(width);
            rows[n].mirror  = fx;
            rows[n].pal     = 9'((int'(attr_w[3:0]) + int'(srss_pkg::PAL_OFFSET)) * 16);
            rows[n].pri     = attr_w[14];
            rows[n].shadow  = ~attr_w[10];
            rows[n].last    = 1'b0;
            n++;
         end
      end
      for (r = 0; r < n; r++) begin
         if (r == n - 1) rows[r].last = 1'b1;
         pending_spans.push_back(rows[r]);
      end
   endtask

   function automatic int field_bad(string fname, logic signed [63:0] want,
                                    logic signed [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", fname, want, got);
         return 1;
      end
      return 0;
   endfunction

   task automatic compare_beat();
      span_beat_type want;
      int            bad;
      if (pending_spans.size() == 0) begin
         $error("span beat with none expected: screen_line %0d", rsp_screen_line);
         mismatches++;
         return;
      end
      want = pending_spans.pop_front();
      bad  = 0;
      bad += field_bad("screen_line", want.line, rsp_screen_line);
      bad += field_bad("from_sprite_ram", want.ram, rsp_from_sprite_ram);
      bad += field_bad("row_address", want.addr, rsp_row_address);
      bad += field_bad("x_start", want.x_start, rsp_x_start);
      bad += field_bad("span_width", want.width, rsp_span_width);
      bad += field_bad("mirror_x", want.mirror, rsp_mirror_x);
      bad += field_bad("palette_base", want.pal, rsp_palette_base);
      bad += field_bad("front_priority", want.pri, rsp_front_priority);
      bad += field_bad("shadow_enabled", want.shadow, rsp_shadow_enabled);
      bad += field_bad("last_row", want.last, rsp_last_row);
      mismatches += bad;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_flip_x      = 1'b0;
         cfg_flip_y      = 1'b0;
         cfg_single_bank = 1'b0;
         pending_spans.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               srss_pkg::CSR_FLIP_X:      cfg_flip_x = csr_data;
               srss_pkg::CSR_FLIP_Y:      cfg_flip_y = csr_data;
               srss_pkg::CSR_SINGLE_BANK: cfg_single_bank = csr_data;
               default: ;
            endcase
         end
         if (start && !busy)
            predict_spans(req_tile_code, req_x_word, req_y_word, req_attr_word);
         if (rsp_strobe) compare_beat();
      end
      spans_due  <= pending_spans.size();
      fail_count <= mismatches;
   end

endmodule

// ===== sim/testbench.sv =====
// Testbench top: drives sprite entries and register writes into the span setup block.
`timescale 1ns / 1ps

module testbench;
   import srss_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [15:0]        req_tile_code = '0;
   logic [15:0]        req_x_word = '0;
   logic [15:0]        req_y_word = '0;
   logic [15:0]        req_attr_word = '0;
   logic               rsp_strobe;
   logic [7:0]         rsp_screen_line;
   logic               rsp_from_sprite_ram;
   logic [21:0]        rsp_row_address;
   logic signed [16:0] rsp_x_start;
   logic [6:0]         rsp_span_width;
   logic               rsp_mirror_x;
   logic [8:0]         rsp_palette_base;
   logic               rsp_front_priority;
   logic               rsp_shadow_enabled;
   logic               rsp_last_row;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic               csr_data = 1'b0;
   int                 spans_due;
   int                 fail_count;

   sprite_row_span_setup i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_tile_code       (req_tile_code),
      .req_x_word          (req_x_word),
      .req_y_word          (req_y_word),
      .req_attr_word       (req_attr_word),
      .rsp_strobe          (rsp_strobe),
      .rsp_screen_line     (rsp_screen_line),
      .rsp_from_sprite_ram (rsp_from_sprite_ram),
      .rsp_row_address     (rsp_row_address),
      .rsp_x_start         (rsp_x_start),
      .rsp_span_width      (rsp_span_width),
      .rsp_mirror_x        (rsp_mirror_x),
      .rsp_palette_base    (rsp_palette_base),
      .rsp_front_priority  (rsp_front_priority),
      .rsp_shadow_enabled  (rsp_shadow_enabled),
      .rsp_last_row        (rsp_last_row),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   span_checker i_span_check (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("status: fail");
      $finish;
   end

   // start stays high on return; the caller either drives the next beat or lowers it
   task automatic send_entry(input logic [15:0] c, x, y, a);
      start         <= 1'b1;
      req_tile_code <= c;
      req_x_word    <= x;
      req_y_word    <= y;
      req_attr_word <= a;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause_sender(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_block();
      start <= 1'b0;
      do @(posedge clock); while (spans_due != 0 || busy);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(input logic fx, fy, sb);
      logic [1:0] idx[3];
      logic       val[3];
      int         i;
      idx = '{CSR_FLIP_X, CSR_FLIP_Y, CSR_SINGLE_BANK};
      val = '{fx, fy, sb};
      for (i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   // positions cluster near the screen, the flip wrap point and the 16-bit wrap
   function automatic logic [15:0] pick_position(input int span);
      case ($urandom_range(0, 7))
         0: return 16'($urandom_range(64990, 65010));
         1: return 16'($urandom_range(65472, 65535));
         2: return 16'($urandom);
         default: return 16'($urandom_range(0, span));
      endcase
   endfunction

   task automatic random_entry(output logic [15:0] c, x, y, a);
      int pick;
      pick  = $urandom_range(0, 15);
      c     = (pick == 0) ? CODE_EMPTY : 16'($urandom);
      a     = 16'($urandom);
      a[15] = (pick != 1);
      x     = pick_position(340);
      y     = pick_position(260);
   endtask

   task automatic run_directed();
      // reset configuration: banked, no flips
      send_entry(CODE_EMPTY, 16'd10, 16'd100, 16'h8000);
      send_entry(16'h1234, 16'd10, 16'd100, 16'h0000);
      send_entry(16'h0000, 16'd0, 16'd0, 16'h8000);       // all rows above line 16
      send_entry(16'h0ABC, 16'd100, 16'd100, 16'h8000);
      send_entry(16'h1FFF, 16'd50, 16'd200, 16'h80F5);    // size code three both ways
      send_entry(16'h2FFF, 16'd60, 16'd120, 16'hC450);
      send_entry(16'h6ABC, 16'd70, 16'd8, 16'h8040);
      send_entry(16'h3555, 16'd80, 16'd40, 16'h831F);
      pause_sender(3);
      send_entry(16'h0010, 16'd319, 16'd255, 16'h8000);
      send_entry(16'h0020, 16'd320, 16'd50, 16'h8080);
      send_entry(16'h0030, 16'hFFFF, 16'hFFFF, 16'h80C0);
      send_entry(16'h0FF8, 16'd200, 16'd230, 16'h82A0);
      drain_block();
      set_config(1'b1, 1'b1, 1'b1);
      drain_block();
      send_entry(16'hFFFE, 16'd0, 16'd0, 16'h80FF);       // address past 22 bits
      send_entry(16'h0100, 16'd65001, 16'd65001, 16'h8010);
      send_entry(16'h0200, 16'd65000, 16'd65000, 16'h8000);
      send_entry(16'h0300, 16'hFFFF, 16'hFFFF, 16'h8050);
      send_entry(CODE_EMPTY, 16'd10, 16'd10, 16'hFFFF);
      send_entry(16'h8001, 16'd400, 16'd300, 16'hC7FF);
      send_entry(16'h3000, 16'd10, 16'd100, 16'h8000);
      drain_block();
   endtask

   initial begin
      logic [15:0] c, x, y, a;
      int          burst_left;
      int          phase;
      int          k;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      burst_left = 0;
      for (phase = 0; phase < 8; phase++) begin
         set_config(phase[0], phase[1], phase[2]);
         for (k = 0; k < 40; k++) begin
            random_entry(c, x, y, a);
            send_entry(c, x, y, a);
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 7);
               pause_sender(($urandom_range(0, 3) == 0) ? $urandom_range(20, 70)
                                                        : $urandom_range(1, 6));
            end
         end
         drain_block();
      end
      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/srss_pkg.sv
rtl/srss_ctrl.sv
rtl/srss_dp.sv
rtl/sprite_row_span_setup.sv
sim/span_checker.sv
sim/testbench.sv
